// File: rtl/text_to_integer_parser_unit_assert.svh
// Assertion macros shared by the parser unit.
`ifndef TEXT_TO_INTEGER_PARSER_UNIT_ASSERT_SVH
`define TEXT_TO_INTEGER_PARSER_UNIT_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define T2I_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("parser check failed");

// Check that cond holds in the cycle after trig.
`define T2I_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("parser check failed");

`endif

// File: rtl/t2i_pkg.sv
// Types, character codes and helpers for the text to integer parser.
package t2i_pkg;

  localparam logic [15:0] CH_E     = 16'h0065;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_ONE   = 16'h0031;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_LA    = 16'h0061;
  localparam logic [15:0] CH_LF    = 16'h0066;
  localparam logic [15:0] CH_UA    = 16'h0041;
  localparam logic [15:0] CH_UF    = 16'h0046;
  localparam logic [3:0]  TEN      = 4'd10;
  localparam logic [6:0]  MAX_SCALE = 7'd64;

  typedef enum logic [1:0] {
    MODE_BIN = 2'd0,
    MODE_DEC = 2'd1,
    MODE_HEX = 2'd2,
    MODE_NONE = 2'd3
  } radix_mode_t;

  typedef enum logic [1:0] {
    PH_MANT,
    PH_SIGN,
    PH_EXP
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NEG_IN,
    ST_DIV,
    ST_NEG_OUT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DS_HALF,
    DS_FOLD4,
    DS_FOLD8,
    DS_FOLD16,
    DS_FOLD32,
    DS_TIMES10,
    DS_FIX
  } div_step_t;

  function automatic logic [3:0] hex_value(input logic [15:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 4'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = 4'(c - CH_LA) + TEN;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = 4'(c - CH_UA) + TEN;
    end
    return v;
  endfunction

endpackage

// File: rtl/text_to_integer_parser_unit.sv
// Streaming parser: binary, decimal with exponent, or hexadecimal text to integer.
// Takes one character per cycle and holds the result in an output register, so
// characters keep flowing while a result waits. The last character of a string
// is handed to the output register as soon as it is free unless it ends a decimal
// string with a positive exponent n (clamped to 64): then a shared shift-add unit
// scales by ten n times for a positive sign, or divides the magnitude by ten in
// seven shift-add steps per unit for a negative sign; the result then moves to the
// output register. The input is not ready during scaling or while a finished
// result waits for a full output register.
`include "text_to_integer_parser_unit_assert.svh"

module text_to_integer_parser_unit #(
  parameter int WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,   // radix_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // code_unit
  input  logic        s_tlast,    // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata     // value
);
  import t2i_pkg::*;

  state_t           state, state_next;
  radix_mode_t      mode, mode_next;
  phase_t           phase, phase_next;
  logic [WIDTH-1:0] mant, mant_next;
  logic [63:0]      expo, expo_next;
  logic             exp_neg, exp_neg_next;
  logic [WIDTH-1:0] work, work_next;
  logic [6:0]       scnt, scnt_next;
  div_step_t        dstep, dstep_next;
  logic [WIDTH-1:0] quo, quo_next;
  logic [4:0]       prod5, prod5_next;
  logic             neg, neg_next;
  logic             out_valid, out_valid_next;
  logic [WIDTH-1:0] out_data, out_data_next;

  logic [63:0]      mant_w, mant_calc, exp_calc;
  logic [WIDTH-1:0] result;
  logic [WIDTH-1:0] add_a, add_b, add_sum;
  logic [4:0]       rem_fix;
  logic             accept, out_free, do_scale, div_last;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = 64'($signed(out_data));
  assign mant_w    = 64'(mant);
  assign rem_fix   = work[4:0] - prod5;
  assign div_last  = (state == ST_DIV) && (dstep == DS_FIX);

  always_comb begin
    mant_calc    = mant_w;
    exp_calc     = expo;
    phase_next   = phase;
    exp_neg_next = exp_neg;
    unique case (mode)
      MODE_BIN: mant_calc = (mant_w << 1) + 64'(s_tdata == CH_ONE);
      MODE_HEX: mant_calc = (mant_w << 4) + 64'(hex_value(s_tdata));
      MODE_DEC: begin
        if (phase == PH_MANT) begin
          if (s_tdata == CH_E) begin
            phase_next = PH_SIGN;
          end else begin
            mant_calc = (mant_w << 3) + (mant_w << 1) + 64'(s_tdata) - 64'(CH_ZERO);
          end
        end else if (phase == PH_SIGN && s_tdata == CH_PLUS) begin
          phase_next = PH_EXP;
        end else if (phase == PH_SIGN && s_tdata == CH_MINUS) begin
          exp_neg_next = 1'b1;
          phase_next   = PH_EXP;
        end else begin
          exp_calc   = (expo << 3) + (expo << 1) + 64'(s_tdata) - 64'(CH_ZERO);
          phase_next = PH_EXP;
        end
      end
      MODE_NONE: mant_calc = mant_w;
      default:   mant_calc = mant_w;
    endcase
  end

  assign do_scale = (mode == MODE_DEC) && (exp_calc != 64'd0) && !exp_calc[63];
  assign result   = (mode == MODE_NONE) ? '0 : mant_calc[WIDTH-1:0];

  always_comb begin
    add_a = work << 3;
    add_b = work << 1;
    if (state == ST_DIV) begin
      add_a = quo;
      case (dstep)
        DS_HALF: begin
          add_a = work >> 1;
          add_b = work >> 2;
        end
        DS_FOLD4:  add_b = quo >> 4;
        DS_FOLD8:  add_b = quo >> 8;
        DS_FOLD16: add_b = quo >> 16;
        DS_FOLD32: add_b = quo >> 32;
        DS_TIMES10: begin
          add_a = (quo >> 3) << 3;
          add_b = (quo >> 3) << 1;
        end
        DS_FIX:    add_b = WIDTH'(rem_fix >= 5'(TEN));
        default:   add_b = '0;
      endcase
    end
  end

  assign add_sum = add_a + add_b;

  always_comb begin
    state_next     = state;
    mode_next      = cfg_valid ? radix_mode_t'(cfg_data) : mode;
    mant_next      = mant;
    expo_next      = expo;
    work_next      = work;
    scnt_next      = scnt;
    dstep_next     = dstep;
    quo_next       = quo;
    prod5_next     = prod5;
    neg_next       = neg;
    out_valid_next = out_valid && !m_tready;
    out_data_next  = out_data;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mant_next = mant_calc[WIDTH-1:0];
          expo_next = exp_calc;
          if (s_tlast) begin
            mant_next = '0;
            expo_next = '0;
            work_next = result;
            if (do_scale) begin
              scnt_next  = (exp_calc > 64'(MAX_SCALE)) ? MAX_SCALE : exp_calc[6:0];
              state_next = exp_neg_next ? ST_NEG_IN : ST_MUL;
            end else if (out_free) begin
              out_valid_next = 1'b1;
              out_data_next  = result;
            end else begin
              state_next = ST_EMIT;
            end
          end
        end
      end
      ST_MUL: begin
        work_next = add_sum;
        scnt_next = scnt - 7'd1;
        if (scnt == 7'd1) begin
          state_next = ST_EMIT;
        end
      end
      ST_NEG_IN: begin
        neg_next   = work[WIDTH-1];
        work_next  = work[WIDTH-1] ? -work : work;
        dstep_next = DS_HALF;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        quo_next   = add_sum;
        dstep_next = div_step_t'(dstep + 3'd1);
        if (dstep == DS_TIMES10) begin
          quo_next   = quo >> 3;
          prod5_next = add_sum[4:0];
        end
        if (dstep == DS_FIX) begin
          work_next  = add_sum;
          dstep_next = DS_HALF;
          scnt_next  = scnt - 7'd1;
          if (scnt == 7'd1) begin
            state_next = ST_NEG_OUT;
          end
        end
      end
      ST_NEG_OUT: begin
        work_next  = neg ? -work : work;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = work;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_DEC;
      phase     <= PH_MANT;
      mant      <= '0;
      expo      <= '0;
      exp_neg   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mode      <= mode_next;
      out_valid <= out_valid_next;
      mant      <= mant_next;
      expo      <= expo_next;
      if (accept) begin
        phase   <= s_tlast ? PH_MANT : phase_next;
        exp_neg <= s_tlast ? 1'b0 : exp_neg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    work     <= work_next;
    scnt     <= scnt_next;
    dstep    <= dstep_next;
    quo      <= quo_next;
    prod5    <= prod5_next;
    neg      <= neg_next;
    out_data <= out_data_next;
  end

  `T2I_ASSERT_SAME(a_scale_count_live, (state == ST_MUL || state == ST_DIV), (scnt != 7'd0))
  `T2I_ASSERT_SAME(a_rem_in_range, div_last, (rem_fix < 5'(TEN) + 5'(TEN)))
  `T2I_ASSERT_NEXT(a_div_ends, (div_last && scnt == 7'd1), (state == ST_NEG_OUT))
  `T2I_ASSERT_NEXT(a_emit_loads, (state == ST_EMIT && out_free), (out_valid && state == ST_IDLE))

endmodule
